[sv/lpsd_pkg.sv]
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared constants and types for the LRU page stack distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsd_pkg;

  // Geometry of the page store.
  localparam int FRAMES    = 16;
  localparam int ADDR_BITS = 32;
  localparam int POS_W     = $clog2(FRAMES);
  localparam int OCC_W     = $clog2(FRAMES + 1);
  localparam int SHIFT_W   = 5;
  localparam int CFG_W     = 5;

  // Configuration register indexes.
  localparam logic REG_MAX_PAGES  = 1'b0;
  localparam logic REG_PAGE_SHIFT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]   MAX_PAGES_RST  = CFG_W'(FRAMES);
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = SHIFT_W'(12);

  // Distance reported on a page fault (-1).
  localparam logic signed [4:0] DIST_FAULT = 5'sb11111;

  typedef logic [ADDR_BITS-1:0] page_t;

  // Per-cell control from the chain controller.
  typedef struct packed {
    logic live;   // Cell holds a resident page.
    logic load;   // Cell takes its left neighbor's page this cycle.
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/lpsd_cell.sv]
// ----------------------------------------------------------------------------
// lpsd_cell
// One frame of the LRU stack: holds a page number, compares it against the
// probe and takes its left neighbor's page when the stack shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_cell
  import lpsd_pkg::*;
(
  input  wire       clk,
  input  cell_ctl_t ctl,
  input  page_t     probe_page,
  input  page_t     prev_page,
  output page_t     page_q,
  output logic      match
);

  page_t page_r;

  // Stored page moves one place toward the LRU end on a shift.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      page_r <= prev_page;
    end
  end

  // Only a resident page can hit.
  assign match  = ctl.live && (page_r == probe_page);
  assign page_q = page_r;

endmodule

`default_nettype wire

[sv/lru_page_stack_distance.sv]
// ----------------------------------------------------------------------------
// lru_page_stack_distance
// Fully associative LRU page store reporting the stack distance of each
// access, built as a chain of frame cells ordered from MRU to LRU.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle: the page number is compared against
// all sixteen frame cells at once, the matching position is encoded, and on
// the accepting edge the cells up to that position (or up to the fill level
// on a fault) each take their neighbor's page while the first cell takes the
// new page. The result is registered in an output register, and a new
// request is accepted whenever that register is empty or being drained.
// The store starts empty after reset; no clearing pass is needed.
`default_nettype none

module lru_page_stack_distance
  import lpsd_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  // Request channel.
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [ADDR_BITS-1:0]    in_address,
  // Result channel.
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_hit,
  output logic signed [4:0]       out_stack_distance,
  output logic [31:0]             out_fault_total,
  // Configuration port.
  input  wire                     cfg_we,
  input  wire                     cfg_index,
  input  wire  [CFG_W-1:0]        cfg_wdata
);

  logic [CFG_W-1:0]   max_pages_r;
  logic [SHIFT_W-1:0] page_shift_r;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [31:0]        fault_r, fault_nxt;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [4:0]         out_dist_r;

  page_t              probe_page;
  page_t              cell_page [FRAMES];
  logic [FRAMES-1:0]  match;
  cell_ctl_t          cell_ctl  [FRAMES];
  logic               accept;
  logic               any_hit;
  logic [POS_W-1:0]   hit_pos;
  logic [OCC_W-1:0]   cap;
  logic               evict;
  logic [OCC_W-1:0]   limit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pages_r  <= MAX_PAGES_RST;
      page_shift_r <= PAGE_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_PAGES:  max_pages_r  <= cfg_wdata;
        REG_PAGE_SHIFT: page_shift_r <= cfg_wdata[SHIFT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Handshake: take a request when the result register is empty or being drained.
  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;
  assign probe_page = in_address >> page_shift_r;

  // Encode the matching position; resident pages are unique.
  always_comb begin
    hit_pos = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (match[k]) begin
        hit_pos = hit_pos | POS_W'(k);
      end
    end
  end
  assign any_hit = |match;

  // Effective capacity, clamped to 1..FRAMES.
  always_comb begin
    priority if (max_pages_r == '0) begin
      cap = OCC_W'(1);
    end else if (max_pages_r > CFG_W'(FRAMES)) begin
      cap = OCC_W'(FRAMES);
    end else begin
      cap = OCC_W'(max_pages_r);
    end
  end
  assign evict = (occ_r >= cap);

  // Last cell that shifts: hit position, LRU frame on eviction, or the
  // first empty frame when appending.
  always_comb begin
    priority if (any_hit) begin
      limit = OCC_W'(hit_pos);
    end else if (evict) begin
      limit = occ_r - OCC_W'(1);
    end else begin
      limit = occ_r;
    end
  end

  // Occupancy and fault counter updates.
  always_comb begin
    occ_nxt   = occ_r;
    fault_nxt = fault_r;
    if (accept && !any_hit) begin
      if (!evict) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
      if (fault_r != '1) begin
        fault_nxt = fault_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      fault_r <= '0;
    end else begin
      occ_r   <= occ_nxt;
      fault_r <= fault_nxt;
    end
  end

  // Chain of frame cells, MRU at index 0.
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    assign cell_ctl[k].live = (OCC_W'(k) < occ_r);
    assign cell_ctl[k].load = accept && (OCC_W'(k) <= limit);

    lpsd_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[k]),
      .probe_page (probe_page),
      .prev_page  ((k == 0) ? probe_page : cell_page[(k == 0) ? 0 : k - 1]),
      .page_q     (cell_page[k]),
      .match      (match[k])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r  <= any_hit;
      out_dist_r <= any_hit ? 5'(hit_pos) : DIST_FAULT;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_stack_distance = out_dist_r;
  assign out_fault_total    = fault_r;

  // Checks on the chain and counters.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(FRAMES))
    else $error("occupancy exceeds frame count");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("page resident in more than one frame");

  a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    accept && any_hit |=> occ_r == $past(occ_r))
    else $error("occupancy changed on a hit");

  a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !any_hit && fault_r != '1 |=> fault_r == $past(fault_r) + 32'd1)
    else $error("fault counter did not advance on a fault");

  a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !any_hit && !evict |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("store did not grow on a fault with free frames");

endmodule

`default_nettype wire

[verif/lpsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpsd_checker
// Watches the request, result and configuration ports of the LRU page store.
// It keeps its own copy of the page stack and the fault count. For each
// accepted request it works out the hit flag, the stack distance and the
// fault total. Each accepted result is checked, field by field, against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------

module lpsd_checker
  import lpsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [ADDR_BITS-1:0]    in_address,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_hit,
  input  logic signed [4:0]       out_stack_distance,
  input  logic [31:0]             out_fault_total,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output int                      pending_count,
  output int                      error_count
);

  typedef struct packed {
    logic        hit;
    logic [4:0]  distance;
    logic [31:0] faults;
  } access_result_t;

  // Shadow page store: index 0 holds the least recently used page.
  page_t              frame_page [FRAMES];
  int                 resident;
  logic [31:0]        fault_tally;
  logic [CFG_W-1:0]   max_pages_reg;
  logic [SHIFT_W-1:0] page_shift_reg;
  access_result_t     predicted_q [$];

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 100)
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Look up one address in the shadow store and update it the way the
  // block does: move a hit to the MRU end, or insert a faulting page there.
  function automatic access_result_t lru_access(input page_t addr);
    access_result_t r;
    page_t          page;
    int             frames_in_use;
    int             pos;
    int             i;
    page = addr >> page_shift_reg;
    // A capacity of zero acts as one frame, anything above FRAMES as FRAMES.
    if (max_pages_reg == 0)
      frames_in_use = 1;
    else if (max_pages_reg > FRAMES)
      frames_in_use = FRAMES;
    else
      frames_in_use = max_pages_reg;
    pos = -1;
    for (i = 0; i < resident; i++) begin
      if (pos < 0 && frame_page[i] == page)
        pos = i;
    end
    if (pos >= 0) begin
      r.hit      = 1'b1;
      r.distance = 5'(resident - 1 - pos);
      for (i = pos; i < resident - 1; i++)
        frame_page[i] = frame_page[i + 1];
      frame_page[resident - 1] = page;
    end else begin
      r.hit      = 1'b0;
      r.distance = DIST_FAULT;
      if (fault_tally != '1)
        fault_tally++;
      // A full store (or one above a lowered capacity) drops its LRU page
      // and keeps its occupancy; otherwise the page is appended.
      if (resident >= frames_in_use) begin
        for (i = 0; i < resident - 1; i++)
          frame_page[i] = frame_page[i + 1];
        frame_page[resident - 1] = page;
      end else begin
        frame_page[resident] = page;
        resident++;
      end
    end
    r.faults = fault_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      resident       = 0;
      fault_tally    = '0;
      max_pages_reg  = MAX_PAGES_RST;
      page_shift_reg = PAGE_SHIFT_RST;
      error_count    = 0;
      predicted_q.delete();
    end else begin
      // Results are checked before new requests are queued, so a result is
      // never matched against the request accepted on the same edge.
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("result with no request outstanding", out_fault_total, '0);
        end else begin
          want = predicted_q.pop_front();
          if (out_hit !== want.hit)
            report_mismatch("hit", {31'd0, out_hit}, {31'd0, want.hit});
          if (out_stack_distance !== want.distance)
            report_mismatch("stack_distance", {27'd0, out_stack_distance},
                            {27'd0, want.distance});
          if (out_fault_total !== want.faults)
            report_mismatch("fault_total", out_fault_total, want.faults);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_PAGES:  max_pages_reg  = cfg_wdata;
          REG_PAGE_SHIFT: page_shift_reg = cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predicted_q.push_back(lru_access(in_address));
    end
    pending_count = predicted_q.size();
  end

endmodule

[verif/tb_lru_page_stack_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_stack_distance
// Drives memory accesses into the LRU page store and gives the verdict.
// A short directed run covers the field extremes, a single resident page,
// the deepest stack distance and eviction. Random phases follow, one per
// configuration, drawing most addresses from a small page pool so that hits
// and evictions are frequent. Both handshakes idle at random; the checker
// module predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_lru_page_stack_distance;
  import lpsd_pkg::*;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [ADDR_BITS-1:0] in_address = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic                 out_hit;
  logic signed [4:0]    out_stack_distance;
  logic [31:0]          out_fault_total;
  logic                 cfg_we     = 1'b0;
  logic                 cfg_index  = REG_MAX_PAGES;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  int pending_count;
  int error_count;

  // Idle control shared by the request and result sides.
  bit tx_burst        = 1'b0;
  bit rx_burst        = 1'b0;
  int hold_off_cycles = 0;

  lru_page_stack_distance dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_stack_distance (out_stack_distance),
    .out_fault_total    (out_fault_total),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  lpsd_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_stack_distance (out_stack_distance),
    .out_fault_total    (out_fault_total),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .pending_count      (pending_count),
    .error_count        (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, bursts with no stall, and one long hold-off.
  initial begin
    int stall;
    forever begin
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one access after a random gap and hold it until it is taken.
  task automatic send_request(input logic [ADDR_BITS-1:0] addr);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // Write both registers on back-to-back edges while the block is idle.
  task automatic apply_config(input int max_pages, input int page_shift);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_PAGES;
    cfg_wdata <= CFG_W'(max_pages);
    @(posedge clk);
    cfg_index <= REG_PAGE_SHIFT;
    cfg_wdata <= CFG_W'(page_shift);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stimulus: directed accesses, then one random phase per configuration.
  initial begin
    int          max_list   [10] = '{16, 4, 1, 0, 31, 8, 2, 16, 12, 5};
    int          shift_list [10] = '{12, 12, 0, 31, 5, 20, 31, 0, 7, 31};
    int          count_list [10] = '{120, 80, 60, 50, 90, 80, 40, 100, 80, 50};
    page_t       page_pool  [24];
    int          pool_size;
    int          frames_in_use;
    int          ph;
    int          k;
    logic [31:0] offset_mask;
    page_t       addr;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed run with the reset configuration: 16 frames, 4 KiB pages.
    send_request(32'h0000_0000);        // fault into an empty store
    send_request(32'h0000_0FFF);        // hit with a single resident page
    send_request(32'hFFFF_FFFF);        // top page, all address bits set
    send_request(32'hFFFF_F000);        // hit at the MRU position
    send_request(32'h0000_0123);        // hit one position down
    for (k = 2; k < 16; k++)
      send_request(page_t'(k) << 12);   // fill the store
    send_request(32'hFFFF_F800);        // hit on the LRU page, deepest distance
    send_request(32'h0010_0000);        // fault with a full store evicts LRU
    send_request(32'h0000_0ABC);        // the evicted page faults again
    wait_drained();

    // Random phases; the store carries over, so each new shift meets the
    // pages left resident by the previous one, and phase two lowers the
    // capacity below the current occupancy.
    for (ph = 0; ph < 10; ph++) begin
      apply_config(max_list[ph], shift_list[ph]);
      tx_burst = (ph % 3 == 2);
      rx_burst = (ph % 4 == 3);
      if (max_list[ph] == 0)
        frames_in_use = 1;
      else if (max_list[ph] > FRAMES)
        frames_in_use = FRAMES;
      else
        frames_in_use = max_list[ph];
      pool_size = frames_in_use + $urandom_range(1, 6);
      if (pool_size > 24)
        pool_size = 24;
      for (k = 0; k < pool_size; k++)
        page_pool[k] = $urandom;
      offset_mask = 32'((64'd1 << shift_list[ph]) - 64'd1);

      for (k = 0; k < count_list[ph]; k++) begin
        // Long result hold-off while requests keep coming with no gaps.
        if (ph == 0 && k == 40) begin
          hold_off_cycles = 80;
          tx_burst        = 1'b1;
        end
        if (ph == 0 && k == 70)
          tx_burst = 1'b0;
        // Sender pauses until every outstanding result has come back.
        if (ph == 4 && k == 45)
          wait_drained();
        // Mostly pages from the pool with random offsets; some raw noise.
        if ($urandom_range(0, 99) < 85)
          addr = (page_pool[$urandom_range(0, pool_size - 1)] & ~offset_mask) |
                 (page_t'($urandom) & offset_mask);
        else
          addr = $urandom;
        send_request(addr);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
